### design/afsu_pkg.sv
// Shared types and constants for the ADC frame sample unpacker.
// No dependencies; imported by every module of the block.
package afsu_pkg;

  // Configuration register indexes
  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_WIDE_SAMPLES  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;
  localparam logic       WIDE_SAMPLES_RESET  = 1'b1;

  // Sample lengths in bytes
  localparam logic [1:0] NARROW_BYTES = 2'd2;
  localparam logic [1:0] WIDE_BYTES   = 2'd3;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One data byte of a sample, classified by the front end
  typedef struct packed {
    logic [7:0]  data;       // raw byte
    logic        first;      // first byte of a sample: restart accumulation
    logic        done;       // final byte of a sample: emit a result
    logic [2:0]  channel;    // channel number, masked to 3 bits
    logic [31:0] seq_num;    // frame sequence number
    logic        last;       // final channel of the frame
  } byte_op_t;

endpackage

### design/afsu_front.sv
// Front end: accepts bytes, tracks frame position and channel, holds config.
// Depends on afsu_pkg; pushes classified data bytes into afsu_queue.
module afsu_front import afsu_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int STATUS_BYTES = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       cfg_valid,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data,
  output logic       push,
  output byte_op_t   op
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int PW = $clog2(STATUS_BYTES + 2);
  localparam logic [4:0]    MAX_CH5    = 5'(MAX_CHANNELS);
  localparam logic [PW-1:0] STATUS_LIM = PW'(STATUS_BYTES);

  // Configuration registers
  logic [3:0] channel_count;
  logic       wide_samples;

  // Frame tracking registers
  logic [PW-1:0] byte_position, byte_position_next;
  logic [1:0]    byte_in_sample, byte_in_sample_next;
  logic [CW-1:0] current_channel, current_channel_next;
  logic          past_end, past_end_next;
  logic [31:0]   frame_counter, frame_counter_next;

  // Working copies after a frame start is applied
  logic [PW-1:0] pos_w;
  logic [1:0]    bis_w;
  logic [CW-1:0] ch_w;
  logic          past_w;
  logic [31:0]   fc_w;

  logic [4:0]    nch;
  logic [4:0]    ch5;
  logic [4:0]    ch5_inc;
  logic [1:0]    sample_bytes;
  logic [1:0]    bis_inc;
  logic          sample_done;
  logic [CW+2:0] ch_ext;

  // Effective channel count, saturated
  assign nch          = ({1'b0, channel_count} > MAX_CH5) ? MAX_CH5 : {1'b0, channel_count};
  assign sample_bytes = wide_samples ? WIDE_BYTES : NARROW_BYTES;

  // Frame start restarts the frame state
  always_comb begin
    pos_w  = byte_position;
    bis_w  = byte_in_sample;
    ch_w   = current_channel;
    past_w = past_end;
    fc_w   = frame_counter;
    if (frame_start) begin
      pos_w  = '0;
      bis_w  = '0;
      ch_w   = '0;
      past_w = 1'b0;
      fc_w   = frame_counter + 32'd1;
    end
  end

  assign ch5         = 5'(ch_w);
  assign ch5_inc     = ch5 + 5'd1;
  assign bis_inc     = bis_w + 2'd1;
  assign sample_done = (bis_inc >= sample_bytes);
  assign ch_ext      = (CW+3)'(ch_w);

  // Byte classification and next state
  always_comb begin
    byte_position_next   = byte_position;
    byte_in_sample_next  = byte_in_sample;
    current_channel_next = current_channel;
    past_end_next        = past_end;
    frame_counter_next   = frame_counter;
    push                 = 1'b0;
    if (fire) begin
      byte_position_next   = pos_w;
      byte_in_sample_next  = bis_w;
      current_channel_next = ch_w;
      past_end_next        = past_w;
      frame_counter_next   = fc_w;
      priority if (past_w) begin
        // outside a frame: drop
      end else if (pos_w < STATUS_LIM) begin
        byte_position_next = pos_w + PW'(1);
      end else if (ch5 >= nch) begin
        past_end_next = 1'b1;
      end else begin
        push = 1'b1;
        if (sample_done) begin
          byte_in_sample_next  = '0;
          current_channel_next = ch_w + CW'(1);
          if (ch5_inc >= nch) past_end_next = 1'b1;
        end else begin
          byte_in_sample_next = bis_inc;
        end
      end
    end
  end

  // Queue entry
  always_comb begin
    op.data    = data_byte;
    op.first   = (bis_w == 2'd0);
    op.done    = sample_done;
    op.channel = ch_ext[2:0];
    op.seq_num = fc_w - 32'd1;
    op.last    = (ch5_inc >= nch);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      byte_in_sample  <= '0;
      current_channel <= '0;
      past_end        <= 1'b1;
      frame_counter   <= '0;
    end else begin
      byte_position   <= byte_position_next;
      byte_in_sample  <= byte_in_sample_next;
      current_channel <= current_channel_next;
      past_end        <= past_end_next;
      frame_counter   <= frame_counter_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
      wide_samples  <= WIDE_SAMPLES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data;
        CFG_WIDE_SAMPLES:  wide_samples  <= cfg_data[0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Channel number never runs past the saturated maximum
  assert property (@(posedge clk) disable iff (rst) 5'(current_channel) <= MAX_CH5)
    else $error("afsu_front: channel number out of range");
  // A pushed byte always belongs to a channel inside the frame
  assert property (@(posedge clk) disable iff (rst) push |-> (ch5 < nch) && fire)
    else $error("afsu_front: data byte pushed outside a frame");
  // After the final channel's last byte the frame is closed
  assert property (@(posedge clk) disable iff (rst)
    (push && op.done && op.last) |=> past_end)
    else $error("afsu_front: frame not closed after last channel");
`endif

endmodule

### design/afsu_queue.sv
// Two-entry queue of classified bytes between front and back end.
// Depends on afsu_pkg for the entry type and depth.
module afsu_queue import afsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  byte_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output byte_op_t pop_op
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  byte_op_t entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic do_push, do_pop;

  assign full      = (count == NW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_op    = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  // Front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("afsu_queue: push while full");
  // Fill count stays within depth
  assert property (@(posedge clk) disable iff (rst) count <= NW'(QUEUE_DEPTH))
    else $error("afsu_queue: count overflow");
`endif

endmodule

### design/afsu_back.sv
// Back end: assembles sample bytes and drives the registered result beat.
// Depends on afsu_pkg for the queue entry type.
module afsu_back import afsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  input  byte_op_t    op,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] sample_value,
  output logic [2:0]  channel_index,
  output logic [31:0] sequence_number,
  output logic        last_channel
);

  logic [23:0] accum, accum_next;
  logic        slot_free;

  // Take an entry whenever the result slot can be refilled
  assign slot_free  = !out_valid || out_ready;
  assign pop        = op_valid && slot_free;
  assign accum_next = op.first ? {16'd0, op.data} : {accum[15:0], op.data};

  // Accumulator
  always_ff @(posedge clk) begin
    if (pop) accum <= accum_next;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && op.done) begin
      sample_value    <= accum_next;
      channel_index   <= op.channel;
      sequence_number <= op.seq_num;
      last_channel    <= op.last;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && op.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // No byte at all is taken while a result is stuck
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("afsu_back: pop while result stalled");
  // A finished sample shows up as a result beat in the next cycle
  assert property (@(posedge clk) disable iff (rst) (pop && op.done) |=> out_valid)
    else $error("afsu_back: finished sample not presented");
`endif

endmodule

### design/adc_frame_sample_unpacker_top.sv
// A result goes valid once its final byte has passed the queue into the registered slot.
// Throughput: one byte per cycle; the front end and the registered result slot are
// parted by a two-entry queue, so a stalled output stops input only once it fills.
// Reset (rst, synchronous): awaits a frame start, sequence count zero,
// channel_count = 8, wide_samples = 1, queue and result slot empty.
module adc_frame_sample_unpacker_top import afsu_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int STATUS_BYTES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] sample_value,
  output logic [2:0]  channel_index,
  output logic [31:0] sequence_number,
  output logic        last_channel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  logic     in_fire;
  logic     push, full, pop, op_valid;
  byte_op_t push_op, pop_op;

  assign in_ready  = !full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  afsu_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .STATUS_BYTES(STATUS_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .data_byte  (data_byte),
    .frame_start(frame_start),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .op         (push_op)
  );

  afsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (full),
    .pop      (pop),
    .pop_valid(op_valid),
    .pop_op   (pop_op)
  );

  afsu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (op_valid),
    .op             (pop_op),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_value   (sample_value),
    .channel_index  (channel_index),
    .sequence_number(sequence_number),
    .last_channel   (last_channel)
  );

endmodule

### bench/tb.sv
// Testbench for adc_frame_sample_unpacker_top: directed frames with hand-written results,
// then random frames across many register settings, checked against an in-bench frame predictor.
// Depends on afsu_pkg and the block's top module only.
module tb;
  import afsu_pkg::*;

  localparam int MAX_CH   = 8;
  localparam int STATUS_N = 3;

  // One expected channel sample
  typedef struct packed {
    logic [23:0] value;
    logic [2:0]  chan;
    logic [31:0] seq;
    logic        last;
  } sample_rec_t;

  // One directed beat, with an optional hand-written result
  typedef struct {
    logic [7:0]  b;
    logic        s;
    bit          typed;
    sample_rec_t r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] sample_value;
  logic [2:0]  channel_index;
  logic [31:0] sequence_number;
  logic        last_channel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [3:0]  cfg_data;

  // Frame predictor state and its copy of the registers
  logic [3:0]  reg_chan_count;
  logic        reg_wide;
  int          fr_status_seen;
  bit          fr_past_end;
  int          fr_bytes_taken;
  logic [23:0] fr_acc;
  int          fr_chan;
  logic [31:0] fr_count;
  bit          byte_used;

  sample_rec_t pending_samples[$];
  sample_rec_t seen_exp;
  int          fail_count = 0;
  int          used_items = 0;
  int          burst_left = 0;
  bit          long_hold_req = 1'b0;

  // Reset config: 8 channels, 24-bit samples
  dir_row_t directed_rows [24] = '{
    '{8'hC3, 1'b0, 1'b0, '0},   // before any frame start: ignored
    '{8'h00, 1'b1, 1'b0, '0},   // frame 0, status
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, {24'hFFFFFF, 3'd0, 32'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, {24'h000000, 3'd1, 32'd0, 1'b0}},
    '{8'h7E, 1'b1, 1'b0, '0},   // restart mid-frame: frame 1
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b1, {24'h123456, 3'd0, 32'd1, 1'b0}},
    '{8'hAB, 1'b0, 1'b0, '0},   // partial sample, dropped below
    '{8'hCD, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},   // frame 2
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b1, {24'h010203, 3'd0, 32'd2, 1'b0}}
  };

  adc_frame_sample_unpacker_top #(
    .MAX_CHANNELS(MAX_CH),
    .STATUS_BYTES(STATUS_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_value(sample_value),
    .channel_index(channel_index),
    .sequence_number(sequence_number),
    .last_channel(last_channel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predict the sample (if any) completed by one accepted byte
  function automatic bit unpack_byte(input logic [7:0] b, input logic s,
                                     output sample_rec_t r);
    int nch;
    int need;
    nch  = (reg_chan_count > MAX_CH) ? MAX_CH : int'(reg_chan_count);
    need = reg_wide ? int'(WIDE_BYTES) : int'(NARROW_BYTES);
    r = '0;
    byte_used = 1'b0;
    if (s) begin
      fr_status_seen = 0;
      fr_bytes_taken = 0;
      fr_acc         = '0;
      fr_chan        = 0;
      fr_past_end    = 1'b0;
      fr_count       = fr_count + 32'd1;
    end
    if (fr_past_end) return 1'b0;
    byte_used = 1'b1;
    if (fr_status_seen < STATUS_N) begin
      fr_status_seen++;
      return 1'b0;
    end
    if (fr_chan >= nch) begin
      fr_past_end = 1'b1;
      return 1'b0;
    end
    fr_acc = {fr_acc[15:0], b};
    fr_bytes_taken++;
    if (fr_bytes_taken < need) return 1'b0;
    r.value = fr_acc;
    r.chan  = fr_chan[2:0];
    r.seq   = fr_count - 32'd1;
    r.last  = (fr_chan + 1 >= nch);
    fr_chan++;
    fr_bytes_taken = 0;
    fr_acc = '0;
    if (fr_chan >= nch) fr_past_end = 1'b1;
    return 1'b1;
  endfunction

  // Offer one byte, wait for its beat, then maybe idle the input
  task automatic send_byte(input logic [7:0] b, input logic s,
                           input bit has_typed, input sample_rec_t typed);
    sample_rec_t r;
    bit got;
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = unpack_byte(b, s, r);
    if (byte_used) used_items++;
    if (has_typed) pending_samples.push_back(typed);
    else if (got) pending_samples.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // Register write; input side is idle whenever this runs
  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHANNEL_COUNT) reg_chan_count = val;
    else reg_wide = val[0];
    @(posedge clk);
  endtask

  // Stop input, wait for all samples, then let the pipeline settle
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_samples.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, pending_samples.size());
      fail_count++;
      pending_samples.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // One frame: mostly well formed, some cut short, some noise
  task automatic send_frame();
    int nch;
    int full;
    int mode;
    int len;
    logic [7:0] b;
    logic s;
    nch  = (reg_chan_count > MAX_CH) ? MAX_CH : int'(reg_chan_count);
    full = STATUS_N + nch * (reg_wide ? int'(WIDE_BYTES) : int'(NARROW_BYTES));
    mode = $urandom_range(0, 9);
    if (mode <= 6) len = full + $urandom_range(0, 2);
    else if (mode <= 8) len = $urandom_range(1, full);
    else len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      b = ($urandom_range(0, 7) == 0) ? 8'h00 :
          ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
      if (mode == 9) s = ($urandom_range(0, 7) == 0);
      else s = (k == 0);
      send_byte(b, s, 1'b0, '0);
    end
  endtask

  // Result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample: value %h ch %0d seq %0d last %0d", $time,
                 sample_value, channel_index, sequence_number, last_channel);
        fail_count++;
      end else begin
        seen_exp = pending_samples.pop_front();
        if ({sample_value, channel_index, sequence_number, last_channel} !== seen_exp) begin
          $display("%0t: expected value %h ch %0d seq %0d last %0d", $time, seen_exp.value,
                   seen_exp.chan, seen_exp.seq, seen_exp.last);
          $display("%0t:   actual value %h ch %0d seq %0d last %0d", $time, sample_value,
                   channel_index, sequence_number, last_channel);
          fail_count++;
        end
      end
    end
  end

  // Output side: stall patterns that change every so often, plus long holds on request
  initial begin : result_sink
    int mode;
    int span;
    int hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        if (long_hold_req) begin
          hold_left = 400;
          long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [3:0] cc;
    logic [3:0] wd;
    int phase_goal;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    frame_start = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_CHANNEL_COUNT;
    cfg_data    = 4'h0;
    reg_chan_count = CHANNEL_COUNT_RESET;
    reg_wide       = WIDE_SAMPLES_RESET;
    fr_status_seen = 0;
    fr_past_end    = 1'b1;
    fr_bytes_taken = 0;
    fr_acc         = '0;
    fr_chan        = 0;
    fr_count       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings
    for (int i = 0; i < 24; i++)
      send_byte(directed_rows[i].b, directed_rows[i].s, directed_rows[i].typed,
                directed_rows[i].r);
    drain_results();

    // Random phases, each with its own register settings
    phase_goal = used_items;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin cc = 4'd1;  wd = 4'd0; end
        1: begin cc = 4'd0;  wd = 4'd1; end
        2: begin cc = 4'd8;  wd = 4'd1; end
        3: begin cc = 4'd15; wd = {3'($urandom), 1'b0}; end
        4: begin cc = 4'($urandom_range(9, 14)); wd = {3'($urandom), 1'b1}; end
        default: begin
          cc = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
          wd = 4'($urandom);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_CHANNEL_COUNT, cc);
        write_reg(CFG_WIDE_SAMPLES, wd);
      end else begin
        write_reg(CFG_WIDE_SAMPLES, wd);
        write_reg(CFG_CHANNEL_COUNT, cc);
      end
      if (ph == 2 || ph == 7) long_hold_req = 1'b1;
      phase_goal += 146;
      while (used_items < phase_goal) send_frame();
      drain_results();
    end

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #(12 * 600000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
